// File: sv/ffl_pkg.sv
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared constants, entry layout and controller/datapath interface types
// for the first-fit free list unit.
// ----------------------------------------------------------------------------
package ffl_pkg;

  // List geometry and field widths
  localparam int DEPTH         = 32;
  localparam int OFFSET_BITS   = 32;
  localparam int SIZE_BITS     = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int KIND_BITS     = 3;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);

  // Stream widths
  localparam int IN_DATA_W   = 56;  // offset, size, priority
  localparam int IN_USER_W   = KIND_BITS;
  localparam int OUT_DATA_W  = 64;  // offset, size, priority, entries held
  localparam int OUT_USER_W  = 2;   // found, refused

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_TAKE       = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POP        = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR      = 3'd4;

  // Write address select
  localparam logic [1:0] WA_IDX      = 2'd0;
  localparam logic [1:0] WA_IDX_NEXT = 2'd1;
  localparam logic [1:0] WA_COUNT    = 2'd2;

  // One stored hole
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] priority_val;
    logic [SIZE_BITS-1:0]     size;
    logic [OFFSET_BITS-1:0]   offset;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_req;     // capture request, clear result, idx <= 0
    logic       rd_en;        // read memory
    logic       rd_next;      // read address idx+1 instead of idx
    logic       wr_en;        // write memory
    logic [1:0] wr_sel;       // write address select
    logic       wr_from_req;  // write data from request, else from read data
    logic       idx_load_top; // idx <= count-1
    logic       idx_inc;
    logic       idx_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       set_refused;
    logic       capture;      // latch read data as the returned hole
    logic       out_load;     // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 full;
    logic                 empty;
    logic                 fit;       // read entry is large enough
    logic                 idx_zero;
    logic                 idx_end;   // idx is the last held slot
    logic                 idx_end2;  // idx+1 is the last held slot
  } status_t;

endpackage

// File: sv/ffl_ctrl.sv
// ----------------------------------------------------------------------------
// ffl_ctrl
// Sequencer for the free list: dispatches each request and steps the
// memory scan and shift loops, each slot a memory read then a write or check.
// ----------------------------------------------------------------------------
module ffl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ffl_pkg::status_t st,
  output ffl_pkg::cmd_t    cmd
);
  import ffl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_WR   = 4'd3;
  localparam logic [3:0] S_UP_HEAD = 4'd4;
  localparam logic [3:0] S_SCAN_RD = 4'd5;
  localparam logic [3:0] S_SCAN_CK = 4'd6;
  localparam logic [3:0] S_DN_RD   = 4'd7;
  localparam logic [3:0] S_DN_WR   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (st.kind)
          KIND_PUSH_BACK: begin
            if (st.full) begin
              cmd.set_refused = 1'b1;
            end else begin
              cmd.wr_en       = 1'b1;
              cmd.wr_sel      = WA_COUNT;
              cmd.wr_from_req = 1'b1;
              cmd.cnt_inc     = 1'b1;
            end
          end
          KIND_PUSH_FRONT: begin
            if (st.full) begin
              cmd.set_refused = 1'b1;
            end else if (st.empty) begin
              cmd.wr_en       = 1'b1;
              cmd.wr_sel      = WA_IDX;
              cmd.wr_from_req = 1'b1;
              cmd.cnt_inc     = 1'b1;
            end else begin
              cmd.idx_load_top = 1'b1;
              state_next       = S_UP_RD;
            end
          end
          KIND_TAKE, KIND_POP: begin
            if (!st.empty) begin
              state_next = S_SCAN_RD;
            end
          end
          KIND_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // Open the head: move entries up one slot, tail first
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_IDX_NEXT;
        if (st.idx_zero) begin
          state_next = S_UP_HEAD;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_UP_RD;
        end
      end
      S_UP_HEAD: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = WA_IDX;
        cmd.wr_from_req = 1'b1;
        cmd.cnt_inc     = 1'b1;
        state_next      = S_DONE;
      end
      // First-fit search from the head; a pop takes the head entry
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (st.fit || st.kind == KIND_POP) begin
          cmd.capture = 1'b1;
          if (st.idx_end) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_DONE;
          end else begin
            state_next = S_DN_RD;
          end
        end else if (st.idx_end) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      // Close the gap: move later entries down one slot
      S_DN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_IDX;
        if (st.idx_end2) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DN_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is only produced after the request has been dispatched
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !in_ready)
    else $error("result loaded while idle");

  // Loading a result never drops one still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output overwritten");

  // A request is accepted only into the dispatch step
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted request not dispatched");

endmodule

// File: sv/ffl_dp.sv
// ----------------------------------------------------------------------------
// ffl_dp
// Datapath for the free list: hole memory with registered read, request
// and result registers, slot index and fill count, output register.
// ----------------------------------------------------------------------------
module ffl_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ffl_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [ffl_pkg::IN_USER_W-1:0]      in_user,
  output logic [ffl_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [ffl_pkg::OUT_USER_W-1:0]     out_user,
  input  ffl_pkg::cmd_t                      cmd,
  output ffl_pkg::status_t                   st
);
  import ffl_pkg::*;

  entry_t               mem [DEPTH];
  entry_t               rd_data;
  entry_t               req;
  logic [KIND_BITS-1:0] req_kind;
  entry_t               res;
  logic                 found;
  logic                 refused;
  logic [IDX_W-1:0]     idx;
  logic [CNT_W-1:0]     count;

  logic [IDX_W-1:0]     idx_plus1;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic [CNT_W:0]       idx_wide;

  // Address and data selection
  assign idx_plus1 = idx + IDX_W'(1);
  assign rd_addr   = cmd.rd_next ? idx_plus1 : idx;
  assign wr_data   = cmd.wr_from_req ? req : rd_data;

  always_comb begin
    case (cmd.wr_sel)
      WA_IDX:      wr_addr = idx;
      WA_IDX_NEXT: wr_addr = idx_plus1;
      WA_COUNT:    wr_addr = count[IDX_W-1:0];
      default:     wr_addr = idx;
    endcase
  end

  // Hole memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Index and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load_req) begin
        idx <= '0;
      end else if (cmd.idx_load_top) begin
        idx <= IDX_W'(count - CNT_W'(1));
      end else if (cmd.idx_inc) begin
        idx <= idx_plus1;
      end else if (cmd.idx_dec) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      refused <= 1'b0;
    end else if (cmd.load_req) begin
      found   <= 1'b0;
      refused <= 1'b0;
    end else begin
      if (cmd.capture) begin
        found <= 1'b1;
      end
      if (cmd.set_refused) begin
        refused <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req.offset       <= in_data[OFFSET_BITS-1:0];
      req.size         <= in_data[OFFSET_BITS +: SIZE_BITS];
      req.priority_val <= in_data[OFFSET_BITS+SIZE_BITS +: PRIORITY_BITS];
      req_kind         <= in_user;
      res              <= '0;
    end else if (cmd.capture) begin
      res <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {2'b00, count, res.priority_val, res.size, res.offset};
      out_user <= {refused, found};
    end
  end

  // Status to the controller
  assign idx_wide    = (CNT_W + 1)'(idx);
  assign st.kind     = req_kind;
  assign st.full     = (count == CNT_W'(DEPTH));
  assign st.empty    = (count == '0);
  assign st.fit      = (rd_data.size >= req.size);
  assign st.idx_zero = (idx == '0);
  assign st.idx_end  = (idx_wide + (CNT_W + 1)'(1) == (CNT_W + 1)'(count));
  assign st.idx_end2 = (idx_wide + (CNT_W + 1)'(2) == (CNT_W + 1)'(count));

  // Never grow past the memory
  assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < CNT_W'(DEPTH)))
    else $error("push into full list");

  // Never shrink an empty list
  assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (count != '0))
    else $error("removal from empty list");

  // A captured hole is reported as found
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> found)
    else $error("capture lost");

  // Shift reads stay inside the held slots
  assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.rd_next) |-> ((CNT_W + 1)'(idx_plus1) < (CNT_W + 1)'(count)))
    else $error("shift read beyond tail");

endmodule

// File: sv/first_fit_free_list_unit.sv
// Flow: push back, clear, spare kinds, refused pushes and any request on an empty list
// need only the dispatch step; push front into n >= 1 held entries first moves them up
// one slot, tail first; take/pop scan from the head and, on a hit before the tail, move
// the later entries down one slot; each loop slot is a memory read, then a write or check.
// Throughput: one request in flight; the next is accepted once its predecessor's
// result sits in the output register. Reset empties the list and the output.
// ----------------------------------------------------------------------------
// first_fit_free_list_unit
// Ordered free-hole list with push back, push front, first-fit take, pop
// head and clear, built as a sequencer and a memory datapath.
// ----------------------------------------------------------------------------
module first_fit_free_list_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_offset[31:0], entry_size[47:32], entry_priority[55:48]
  input  logic [ffl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind[2:0]
  input  logic [ffl_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hole_offset[31:0], hole_size[47:32], hole_priority[55:48],
  // entries_held[61:56], zero[63:62]
  output logic [ffl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // found[0], refused[1]
  output logic [ffl_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
  import ffl_pkg::*;

  cmd_t    cmd;
  status_t st;

  ffl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ffl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
